[hw/rtl/mqmm_pkg.sv]
`timescale 1ns / 1ps
package mqmm_pkg;
    localparam int NUM_QUEUES = 16;
    localparam int QID_W      = 4;
    localparam int POOL_SLOTS = 256;
    localparam int SLOT_W     = 8;
    localparam int CNT_W      = 9;
    localparam int RCNT_W     = 5;
    localparam int PAY_W      = 128;

    typedef enum logic [1:0] {
        ACT_PUSH,
        ACT_POP,
        ACT_POP_READY,
        ACT_RELIST
    } t_action;

    typedef enum logic [2:0] {
        STS_OK,
        STS_OVERLOAD,
        STS_NO_SLOT,
        STS_EMPTY,
        STS_LISTED
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [QID_W-1:0]   queue;
        logic [31:0]        source;
        logic signed [31:0] session;
        logic [31:0]        data;
        logic [31:0]        size;
    } t_item;

    typedef struct packed {
        logic take;
        logic fire;
    } t_ctrl;
endpackage

[hw/rtl/mqmm_ram.sv]
`timescale 1ns / 1ps
module mqmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/mqmm_front.sv]
`timescale 1ns / 1ps
module mqmm_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_action,
    input  logic [3:0]             i_queue_id,
    input  logic [31:0]            i_source,
    input  logic signed [31:0]     i_session,
    input  logic [31:0]            i_data_handle,
    input  logic [31:0]            i_payload_size,
    output logic                   o_item_valid,
    input  logic                   i_item_take,
    output mqmm_pkg::t_item        o_item
);
    import mqmm_pkg::*;

    t_item      r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      item_in;
    logic       push;
    logic       pop;

    always_comb begin
        item_in.action  = t_action'(i_action);
        item_in.queue   = i_queue_id;
        item_in.source  = i_source;
        item_in.session = i_session;
        item_in.data    = i_data_handle;
        item_in.size    = i_payload_size;
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = o_item_valid && i_item_take;
    assign o_item       = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

[hw/rtl/mqmm_back.sv]
`timescale 1ns / 1ps
module mqmm_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [8:0]             i_threshold,
    input  logic                   i_item_valid,
    output logic                   o_item_take,
    input  mqmm_pkg::t_item        i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2:0]             o_status,
    output logic [3:0]             o_out_queue,
    output logic [31:0]            o_out_source,
    output logic signed [31:0]     o_out_session,
    output logic [31:0]            o_out_data,
    output logic [31:0]            o_out_size,
    output logic [8:0]             o_queue_length,
    output logic                   o_newly_listed
);
    import mqmm_pkg::*;

    t_state r_state;
    t_state n_state;
    t_ctrl  ctrl;
    t_item  r_cur;

    logic [CNT_W-1:0]  r_fresh;
    logic [CNT_W-1:0]  r_rec_cnt;
    logic [SLOT_W-1:0] r_free_head;
    logic [SLOT_W-1:0] r_qhead  [NUM_QUEUES];
    logic [SLOT_W-1:0] r_qtail  [NUM_QUEUES];
    logic [CNT_W-1:0]  r_qcount [NUM_QUEUES];
    logic              r_listed [NUM_QUEUES];
    logic              r_member [NUM_QUEUES];
    logic [QID_W-1:0]  r_rnext  [NUM_QUEUES];
    logic [QID_W-1:0]  r_rhead;
    logic [QID_W-1:0]  r_rtail;
    logic [RCNT_W-1:0] r_rcount;

    logic              r_ovalid;
    logic [2:0]        r_status;
    logic [QID_W-1:0]  r_oq;
    logic [PAY_W-1:0]  r_opay;
    logic [CNT_W-1:0]  r_len;
    logic              r_newly;

    logic [SLOT_W-1:0] next_raddr;
    logic [SLOT_W-1:0] rd_next;
    logic [PAY_W-1:0]  rd_pay;
    logic              next_we;
    logic [SLOT_W-1:0] next_waddr;
    logic [SLOT_W-1:0] next_wdata;
    logic              pay_we;

    logic [QID_W-1:0]  q;
    logic [CNT_W-1:0]  cnt_q;
    logic              have_fresh;
    logic              push_ok;
    logic [SLOT_W-1:0] slot;
    logic              pop_ok;
    logic              rdy_ok;
    logic              app;
    t_status           status;
    logic [QID_W-1:0]  oq;
    logic [CNT_W-1:0]  len;
    logic [PAY_W-1:0]  opay;

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_item_valid) n_state = ST_EXEC;
            ST_EXEC: if (ctrl.fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.take = 1'b0;
        ctrl.fire = 1'b0;
        unique case (r_state)
            ST_IDLE: ctrl.take = i_item_valid;
            ST_EXEC: ctrl.fire = !r_ovalid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_item_take = ctrl.take;

    always_ff @(posedge i_clk) begin
        if (ctrl.take) begin
            r_cur <= i_item;
        end
    end

    assign next_raddr = (i_item.action == ACT_PUSH) ? r_free_head : r_qhead[i_item.queue];

    mqmm_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (ctrl.take),
        .i_raddr (next_raddr),
        .o_rdata (rd_next)
    );

    mqmm_ram #(.WIDTH(PAY_W), .DEPTH(POOL_SLOTS)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (slot),
        .i_wdata ({r_cur.source, r_cur.session, r_cur.data, r_cur.size}),
        .i_re    (ctrl.take),
        .i_raddr (r_qhead[i_item.queue]),
        .o_rdata (rd_pay)
    );

    assign q          = r_cur.queue;
    assign cnt_q      = r_qcount[q];
    assign have_fresh = !r_fresh[CNT_W-1];
    assign push_ok    = have_fresh || (r_rec_cnt != '0);
    assign slot       = have_fresh ? r_fresh[SLOT_W-1:0] : r_free_head;
    assign pop_ok     = (cnt_q != '0);
    assign rdy_ok     = (r_rcount != '0);
    assign app        = !r_member[q] &&
                        ((r_cur.action == ACT_RELIST) ||
                         (r_cur.action == ACT_PUSH && push_ok && !r_listed[q]));

    always_comb begin
        status     = STS_OK;
        oq         = q;
        len        = cnt_q;
        opay       = '0;
        next_we    = 1'b0;
        next_waddr = r_qtail[q];
        next_wdata = slot;
        pay_we     = 1'b0;
        case (r_cur.action)
            ACT_PUSH: begin
                if (!push_ok) begin
                    status = STS_NO_SLOT;
                end else begin
                    len     = cnt_q + CNT_W'(1);
                    status  = (len >= i_threshold) ? STS_OVERLOAD : STS_OK;
                    next_we = ctrl.fire && (cnt_q != '0);
                    pay_we  = ctrl.fire;
                end
            end
            ACT_POP: begin
                if (!pop_ok) begin
                    status = STS_EMPTY;
                end else begin
                    len        = cnt_q - CNT_W'(1);
                    opay       = rd_pay;
                    next_we    = ctrl.fire;
                    next_waddr = r_qhead[q];
                    next_wdata = r_free_head;
                end
            end
            ACT_POP_READY: begin
                if (!rdy_ok) begin
                    status = STS_EMPTY;
                    oq     = '0;
                    len    = '0;
                end else begin
                    oq  = r_rhead;
                    len = r_qcount[r_rhead];
                end
            end
            default: begin
                if (r_member[q]) begin
                    status = STS_LISTED;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh     <= '0;
            r_rec_cnt   <= '0;
            r_free_head <= '0;
            r_rhead     <= '0;
            r_rtail     <= '0;
            r_rcount    <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_qhead[i]  <= '0;
                r_qtail[i]  <= '0;
                r_qcount[i] <= '0;
                r_listed[i] <= 1'b0;
                r_member[i] <= 1'b0;
                r_rnext[i]  <= '0;
            end
        end else if (ctrl.fire) begin
            case (r_cur.action)
                ACT_PUSH: begin
                    if (push_ok) begin
                        if (have_fresh) begin
                            r_fresh <= r_fresh + CNT_W'(1);
                        end else begin
                            r_free_head <= rd_next;
                            r_rec_cnt   <= r_rec_cnt - CNT_W'(1);
                        end
                        if (cnt_q == '0) begin
                            r_qhead[q] <= slot;
                        end
                        r_qtail[q]  <= slot;
                        r_listed[q] <= 1'b1;
                        r_qcount[q] <= cnt_q + CNT_W'(1);
                    end
                end
                ACT_POP: begin
                    if (!pop_ok) begin
                        r_listed[q] <= 1'b0;
                    end else begin
                        r_qcount[q] <= cnt_q - CNT_W'(1);
                        if (cnt_q == CNT_W'(1)) begin
                            r_qhead[q] <= '0;
                            r_qtail[q] <= '0;
                        end else begin
                            r_qhead[q] <= rd_next;
                        end
                        r_free_head <= r_qhead[q];
                        r_rec_cnt   <= r_rec_cnt + CNT_W'(1);
                    end
                end
                ACT_POP_READY: begin
                    if (rdy_ok) begin
                        r_rnext[r_rhead]  <= '0;
                        r_member[r_rhead] <= 1'b0;
                        r_rcount          <= r_rcount - RCNT_W'(1);
                        if (r_rcount == RCNT_W'(1)) begin
                            r_rhead <= '0;
                            r_rtail <= '0;
                        end else begin
                            r_rhead <= r_rnext[r_rhead];
                        end
                    end
                end
                default: ;
            endcase
            if (app) begin
                if (r_rcount == '0) begin
                    r_rhead <= q;
                end else begin
                    r_rnext[r_rtail] <= q;
                end
                r_rtail     <= q;
                r_rnext[q]  <= '0;
                r_member[q] <= 1'b1;
                r_rcount    <= r_rcount + RCNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctrl.fire) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.fire) begin
            r_status <= status;
            r_oq     <= oq;
            r_opay   <= opay;
            r_len    <= len;
            r_newly  <= app && (r_cur.action == ACT_PUSH);
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_out_queue    = r_oq;
    assign o_out_source   = r_opay[127:96];
    assign o_out_session  = r_opay[95:64];
    assign o_out_data     = r_opay[63:32];
    assign o_out_size     = r_opay[31:0];
    assign o_queue_length = r_len;
    assign o_newly_listed = r_newly;
endmodule

[hw/rtl/multi_queue_message_manager.sv]
// Sixteen message FIFOs sharing a 256-slot linked pool, plus a ready list of queue ids.
// Input channel (i_valid/o_ready): one word per action - push, pop message,
// pop ready queue, relist queue. Output channel (o_valid/i_ready): one result
// word per action, in order. Config channel (i_cfg_valid/o_cfg_ready) writes the
// overload threshold; it is always ready and should be written while idle.
// A two-word input queue feeds the execution unit, so input words are taken
// while the back end works or waits on the receiver.
// In the execution unit, state IDLE takes a word and reads the slot link and
// payload memories; state EXEC updates pointers and registers the result.
// The back end takes a new word only once it has registered the result of
// the last one.
// Reset clears all queues and the ready list and sets the threshold to 256; no
// clearing pass is needed, slots are handed out fresh until the pool is used once.
// When the receiver stalls, the result register holds; the back end stops once
// it holds a finished result, and the input queue then fills and drops o_ready.
`timescale 1ns / 1ps
module multi_queue_message_manager (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [3:0]         i_queue_id,
    input  logic [31:0]        i_source,
    input  logic signed [31:0] i_session,
    input  logic [31:0]        i_data_handle,
    input  logic [31:0]        i_payload_size,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [3:0]         o_out_queue,
    output logic [31:0]        o_out_source,
    output logic signed [31:0] o_out_session,
    output logic [31:0]        o_out_data,
    output logic [31:0]        o_out_size,
    output logic [8:0]         o_queue_length,
    output logic               o_newly_listed,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_data
);
    import mqmm_pkg::*;

    logic [8:0] r_threshold;
    logic       item_valid;
    logic       item_take;
    t_item      item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 9'd256;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    mqmm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_queue_id     (i_queue_id),
        .i_source       (i_source),
        .i_session      (i_session),
        .i_data_handle  (i_data_handle),
        .i_payload_size (i_payload_size),
        .o_item_valid   (item_valid),
        .i_item_take    (item_take),
        .o_item         (item)
    );

    mqmm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_threshold    (r_threshold),
        .i_item_valid   (item_valid),
        .o_item_take    (item_take),
        .i_item         (item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_out_queue    (o_out_queue),
        .o_out_source   (o_out_source),
        .o_out_session  (o_out_session),
        .o_out_data     (o_out_data),
        .o_out_size     (o_out_size),
        .o_queue_length (o_queue_length),
        .o_newly_listed (o_newly_listed)
    );
endmodule

[sim/tb_multi_queue_message_manager.sv]
`timescale 1ns / 1ps
module tb_multi_queue_message_manager;
    import mqmm_pkg::*;

    typedef struct {
        t_status     status;
        logic [3:0]  queue;
        logic [31:0] source;
        logic [31:0] session;
        logic [31:0] data;
        logic [31:0] size;
        logic [8:0]  length;
        logic        newly;
    } t_answer;

    // behavioral copy of the queue manager plus the queue of expected answers
    class mq_scoreboard;
        logic [8:0]  threshold;
        logic [7:0]  link [POOL_SLOTS];
        logic [31:0] m_src [POOL_SLOTS];
        logic [31:0] m_ses [POOL_SLOTS];
        logic [31:0] m_dat [POOL_SLOTS];
        logic [31:0] m_siz [POOL_SLOTS];
        logic [7:0]  free_head;
        int          free_cnt;
        logic [7:0]  q_head [NUM_QUEUES];
        logic [7:0]  q_tail [NUM_QUEUES];
        int          q_cnt [NUM_QUEUES];
        bit          q_listed [NUM_QUEUES];
        logic [3:0]  r_next [NUM_QUEUES];
        logic [3:0]  r_head, r_tail;
        int          r_cnt;
        bit          r_member [NUM_QUEUES];
        t_answer     pending [$];
        int          errors, checked, n_overload, n_noslot, n_empty, n_listed;

        function void clear();
            threshold = 9'd256;
            for (int i = 0; i < POOL_SLOTS; i++) link[i] = 8'(i + 1);
            free_head = 0;
            free_cnt = POOL_SLOTS;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                q_head[i] = 0; q_tail[i] = 0; q_cnt[i] = 0; q_listed[i] = 0;
                r_next[i] = 0; r_member[i] = 0;
            end
            r_head = 0; r_tail = 0; r_cnt = 0;
            pending.delete();
        endfunction

        function void ready_add(logic [3:0] q);
            if (r_cnt == 0) r_head = q;
            else r_next[r_tail] = q;
            r_tail = q;
            r_next[q] = 0;
            r_member[q] = 1;
            r_cnt++;
        endfunction

        function void note_input(t_action act, logic [3:0] q, logic [31:0] src,
                                 logic [31:0] ses, logic [31:0] dat, logic [31:0] siz);
            t_answer a;
            logic [7:0] s;
            a = '{STS_OK, q, 0, 0, 0, 0, 0, 0};
            case (act)
                ACT_PUSH: begin
                    if (free_cnt == 0) begin
                        a.status = STS_NO_SLOT;
                    end else begin
                        s = free_head;
                        free_head = link[s];
                        free_cnt--;
                        m_src[s] = src; m_ses[s] = ses; m_dat[s] = dat; m_siz[s] = siz;
                        link[s] = 0;
                        if (q_cnt[q] == 0) q_head[q] = s;
                        else link[q_tail[q]] = s;
                        q_tail[q] = s;
                        if (!q_listed[q]) begin
                            q_listed[q] = 1;
                            if (!r_member[q]) begin
                                ready_add(q);
                                a.newly = 1;
                            end
                        end
                        q_cnt[q]++;
                        if (q_cnt[q] >= threshold) a.status = STS_OVERLOAD;
                    end
                end
                ACT_POP: begin
                    if (q_cnt[q] == 0) begin
                        q_listed[q] = 0;
                        a.status = STS_EMPTY;
                    end else begin
                        s = q_head[q];
                        a.source = m_src[s]; a.session = m_ses[s];
                        a.data = m_dat[s]; a.size = m_siz[s];
                        q_head[q] = link[s];
                        q_cnt[q]--;
                        if (q_cnt[q] == 0) begin
                            q_head[q] = 0; q_tail[q] = 0;
                        end
                        link[s] = free_head;
                        free_head = s;
                        free_cnt++;
                    end
                end
                ACT_POP_READY: begin
                    if (r_cnt == 0) begin
                        a.status = STS_EMPTY;
                        a.queue = 0;
                    end else begin
                        a.queue = r_head;
                        r_head = r_next[a.queue];
                        r_next[a.queue] = 0;
                        r_member[a.queue] = 0;
                        r_cnt--;
                        if (r_cnt == 0) begin
                            r_head = 0; r_tail = 0;
                        end
                    end
                end
                default: begin
                    if (r_member[q]) a.status = STS_LISTED;
                    else ready_add(q);
                end
            endcase
            if (!(act == ACT_POP_READY && a.status == STS_EMPTY))
                a.length = 9'(q_cnt[a.queue]);
            case (a.status)
                STS_OVERLOAD: n_overload++;
                STS_NO_SLOT:  n_noslot++;
                STS_EMPTY:    n_empty++;
                STS_LISTED:   n_listed++;
                default: ;
            endcase
            pending.push_back(a);
        endfunction

        function void check_result(t_answer got);
            t_answer e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.queue !== e.queue) begin
                $error("out_queue exp %0d got %0d", e.queue, got.queue); errors++;
            end
            if (got.source !== e.source) begin
                $error("out_source exp %h got %h", e.source, got.source); errors++;
            end
            if (got.session !== e.session) begin
                $error("out_session exp %h got %h", e.session, got.session); errors++;
            end
            if (got.data !== e.data) begin
                $error("out_data exp %h got %h", e.data, got.data); errors++;
            end
            if (got.size !== e.size) begin
                $error("out_size exp %h got %h", e.size, got.size); errors++;
            end
            if (got.length !== e.length) begin
                $error("queue_length exp %0d got %0d", e.length, got.length); errors++;
            end
            if (got.newly !== e.newly) begin
                $error("newly_listed exp %0d got %0d", e.newly, got.newly); errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, o_valid, i_ready;
    logic [1:0]  i_action;
    logic [3:0]  i_queue_id;
    logic [31:0] i_source, i_data_handle, i_payload_size;
    logic signed [31:0] i_session;
    logic [2:0]  o_status;
    logic [3:0]  o_out_queue;
    logic [31:0] o_out_source, o_out_data, o_out_size;
    logic signed [31:0] o_out_session;
    logic [8:0]  o_queue_length;
    logic        o_newly_listed;
    logic        i_cfg_valid, o_cfg_ready;
    logic [8:0]  i_cfg_data;

    multi_queue_message_manager u_dut (.*);

    mq_scoreboard sb;
    int send_idle_pct, recv_stall_pct, hold_off_cycles, cycle_cnt, items_sent;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > 400000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{t_status'(o_status), o_out_queue, o_out_source, o_out_session,
                              o_out_data, o_out_size, o_queue_length, o_newly_listed});
    end

    // valid stays high between back-to-back words; it drops on idle cycles and in drain
    task automatic send_word(t_action act, logic [3:0] q, logic [31:0] src,
                             logic [31:0] ses, logic [31:0] dat, logic [31:0] siz);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_action <= act; i_queue_id <= q; i_source <= src;
        i_session <= ses; i_data_handle <= dat; i_payload_size <= siz;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(act, q, src, ses, dat, siz);
        items_sent++;
    endtask

    task automatic send_random(t_action act, logic [3:0] q);
        send_word(act, q, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [8:0] v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.threshold = v;
        i_cfg_valid <= 0;
    endtask

    // mostly pushes and pops on a few hot queues
    task automatic random_burst(int n, int hot);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 45) send_random(ACT_PUSH, 4'($urandom_range(hot - 1)));
            else if (r < 80) send_random(ACT_POP, 4'($urandom_range(hot - 1)));
            else if (r < 90) send_random(ACT_POP_READY, 4'($urandom));
            else send_random(ACT_RELIST, 4'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        sb.errors = 0; sb.checked = 0;
        i_rst_n = 0; i_valid = 0; i_action = 0; i_queue_id = 0; i_source = 0;
        i_session = 0; i_data_handle = 0; i_payload_size = 0;
        i_cfg_valid = 0; i_cfg_data = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0; items_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty cases, extremes, listing rules
        send_random(ACT_POP_READY, 4'd0);
        send_random(ACT_POP, 4'd15);
        send_word(ACT_PUSH, 4'd15, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_PUSH, 4'd15, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_word(ACT_PUSH, 4'd0, 32'h1, 32'hFFFF_FFFF, 32'h2, 32'h3);
        send_random(ACT_RELIST, 4'd15);
        send_random(ACT_POP_READY, 4'd0);
        send_random(ACT_RELIST, 4'd15);
        send_random(ACT_POP, 4'd15);
        send_random(ACT_POP, 4'd15);
        send_random(ACT_POP, 4'd15);
        send_random(ACT_PUSH, 4'd15);
        send_random(ACT_POP_READY, 4'd0);
        send_random(ACT_POP_READY, 4'd0);
        send_random(ACT_POP_READY, 4'd0);
        send_random(ACT_PUSH, 4'd15);
        send_random(ACT_POP, 4'd0);
        send_random(ACT_POP, 4'd0);

        write_threshold(9'd1);
        send_random(ACT_PUSH, 4'd3);
        send_random(ACT_POP, 4'd3);
        write_threshold(9'd0);
        send_random(ACT_PUSH, 4'd3);
        send_random(ACT_POP, 4'd3);

        // exhaust the pool, then pop every queue in turn to free slots
        write_threshold(9'd256);
        for (int k = 0; k < 258; k++) send_random(ACT_PUSH, 4'($urandom));
        for (int k = 0; k < 270; k++) send_random(ACT_POP, 4'(k % 16));

        write_threshold(9'd4);
        random_burst(200, 4);
        write_threshold(9'd511);
        send_idle_pct = 74;
        random_burst(250, 16);
        recv_stall_pct = 74; send_idle_pct = 0;
        write_threshold(9'd8);
        random_burst(250, 3);
        send_idle_pct = 38; recv_stall_pct = 38;
        random_burst(250, 8);

        // long receiver hold-off so the input fills and stalls
        drain();
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_cycles = 200;
        random_burst(60, 2);
        drain();
        write_threshold(9'd256);
        random_burst(100, 16);

        drain();
        $display("%0d words sent, %0d results checked", items_sent, sb.checked);
        $display("overload %0d, no slot %0d, empty %0d, already listed %0d",
                 sb.n_overload, sb.n_noslot, sb.n_empty, sb.n_listed);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
